>>> rtl/pf16_pkg.sv
package pf16_pkg;

  typedef struct packed {
    logic [63:0] frame_low;
    logic [63:0] frame_high;
  } pf16_in_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               format_error;
  } pf16_out_t;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegChannelCount   = 2'd0;
  localparam logic [1:0] RegBytesPerSample = 2'd1;
  localparam logic [1:0] RegIntegerSamples = 2'd2;
  localparam int unsigned CfgDataWidth     = 4;

  // Frame layout, decoded once per transaction.
  typedef enum logic [3:0] {
    FmtErr, FmtU8Mono, FmtU8Stereo, FmtI16Mono, FmtI24Mono, FmtF32Mono,
    FmtI32Mono, FmtI16Stereo, FmtI24Stereo, FmtI32Stereo, FmtF64Mono,
    FmtF32Stereo, FmtF64Stereo
  } pf16_fmt_e;

  // One float operand normalised to a common form: a 53-bit significand with
  // the hidden bit, an unbiased exponent and classification flags.
  typedef struct packed {
    logic               sign;
    logic               is_nan;
    logic               is_zero;
    logic signed [12:0] expo;
    logic [52:0]        mant;
    logic               dbl;
  } pf16_flt_t;

  // Stage 2 to stage 3: exact product of significand and 32767.
  typedef struct packed {
    logic               sign;
    logic               is_nan;
    logic               is_zero;
    logic signed [12:0] expo;
    logic [67:0]        prod;
    logic               dbl;
  } pf16_mul_t;

endpackage

>>> rtl/pf16_fconv.sv
// Float lane: unpack, multiply by 32767, round to the source precision,
// truncate toward zero and saturate. Three register stages.
module pf16_fconv
  import pf16_pkg::*;
(
  input  logic        clk_i,
  input  logic        en1_i,
  input  logic        en2_i,
  input  logic        en3_i,
  input  logic [63:0] bits_i,
  input  logic        dbl_i,
  output logic [15:0] res_o
);

  pf16_flt_t flt_d, flt_q;
  pf16_mul_t mul_d, mul_q;
  logic [15:0] res_d, res_q;

  // Stage 1: unpack either format into one form.
  always_comb begin
    flt_d = '0;
    flt_d.dbl = dbl_i;
    if (dbl_i) begin
      flt_d.sign    = bits_i[63];
      flt_d.is_nan  = (bits_i[62:52] == 11'h7ff) && (bits_i[51:0] != '0);
      flt_d.is_zero = (bits_i[62:52] == '0);
      flt_d.expo    = $signed({2'b00, bits_i[62:52]}) - 13'sd1075;
      flt_d.mant    = {1'b1, bits_i[51:0]};
    end else begin
      flt_d.sign    = bits_i[31];
      flt_d.is_nan  = (bits_i[30:23] == 8'hff) && (bits_i[22:0] != '0);
      flt_d.is_zero = (bits_i[30:23] == '0);
      flt_d.expo    = $signed({5'b0, bits_i[30:23]}) - 13'sd150;
      flt_d.mant    = {1'b1, bits_i[22:0], 29'd0};
    end
    // Subnormals give products far below one and truncate to zero.
    if (flt_d.is_zero) flt_d.mant = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) flt_q <= flt_d;
  end

  // Stage 2: 32767 * m = (m << 15) - m, a shift and one wide subtract.
  // A single significand sits 29 bits higher, so its exponent drops by 29.
  always_comb begin
    mul_d.sign    = flt_q.sign;
    mul_d.is_nan  = flt_q.is_nan;
    mul_d.is_zero = flt_q.is_zero;
    mul_d.expo    = flt_q.dbl ? flt_q.expo : flt_q.expo - 13'sd29;
    mul_d.dbl     = flt_q.dbl;
    mul_d.prod    = {flt_q.mant, 15'd0} - {15'd0, flt_q.mant};
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) mul_q <= mul_d;
  end

  // Stage 3: value = prod * 2^expo (single ops use the top 24+15 bits).
  logic [67:0] p;
  logic [6:0]  lead;
  logic [67:0] rmask, kept, half, low, rnd, ival;
  logic [6:0]  keepb, drop;
  logic        big, rup;
  logic [7:0]  sh;
  logic [16:0] mag;
  always_comb begin
    p = mul_q.prod;
    // Significand kept: 53 bits (double) or 24 bits (single), counted from
    // the leading one, which sits at bit 67 or 66.
    lead  = p[67] ? 7'd67 : 7'd66;
    keepb = mul_q.dbl ? 7'd53 : 7'd24;
    drop  = lead + 7'd1 - keepb;
    rmask = (68'd1 << drop) - 68'd1;
    low   = p & rmask;
    half  = 68'd1 << (drop - 7'd1);
    kept  = p & ~rmask;
    rup   = (low > half) || ((low == half) && p[drop]);
    rnd   = rup ? kept + (68'd1 << drop) : kept;
    // Integer part: rnd * 2^expo; need |value| up to 2^16.
    big  = 1'b0;
    ival = '0;
    sh   = '0;
    if (mul_q.expo >= 0) begin
      big = (rnd != '0);
    end else if (mul_q.expo < -13'sd68) begin
      ival = '0;
    end else begin
      sh   = 8'(-mul_q.expo);
      ival = rnd >> sh;
    end
    if (ival[67:16] != '0) big = 1'b1;
    mag = {1'b0, ival[15:0]};
    if (mul_q.is_nan || mul_q.is_zero) begin
      res_d = '0;
    end else if (!mul_q.sign) begin
      res_d = (big || mag >= 17'd32767) ? 16'h7fff : mag[15:0];
    end else begin
      res_d = (big || mag >= 17'd32768) ? 16'h8000 : 16'(-mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/pcm_frame_to_int16.sv
// Channel   Handshake          Payload
// in        in_valid/in_ready  pf16_in_t  (frame_low, frame_high)
// out       out_valid/out_ready pf16_out_t (left, right, format_error)
// cfg       cfg_we             cfg_index, cfg_data
//
// One transaction per cycle while the output is not stalled; the stages are
// decode/unpack, multiply, round and saturate, output select. The float datapath sets the depth.
// Reset clears the valid bits and loads the register defaults.
// A stall on the output holds every stage; no transaction is lost.
module pcm_frame_to_int16
  import pf16_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pf16_in_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pf16_out_t               out_data_o
);

  logic [1:0] cc_q;
  logic [3:0] bps_q;
  logic       int_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q  <= 2'd1;
      bps_q <= 4'd2;
      int_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegChannelCount:   cc_q  <= cfg_data_i[1:0];
        RegBytesPerSample: bps_q <= cfg_data_i[3:0];
        RegIntegerSamples: int_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Layout decode.
  pf16_fmt_e fmt;
  logic [4:0] prod;
  always_comb begin
    prod = (cc_q == 2'd2) ? {bps_q, 1'b0} : {1'b0, bps_q};
    fmt  = FmtErr;
    if (cc_q == 2'd1 || cc_q == 2'd2) begin
      unique case (prod)
        5'd1:  fmt = FmtU8Mono;
        5'd2:  fmt = (cc_q == 2'd2) ? FmtU8Stereo : FmtI16Mono;
        5'd3:  fmt = FmtI24Mono;
        5'd4:  fmt = !int_q ? FmtF32Mono : (cc_q == 2'd1) ? FmtI32Mono : FmtI16Stereo;
        5'd6:  fmt = FmtI24Stereo;
        5'd8:  fmt = int_q ? FmtI32Stereo : (cc_q == 2'd1) ? FmtF64Mono : FmtF32Stereo;
        5'd16: fmt = FmtF64Stereo;
        default: fmt = FmtErr;
      endcase
    end
  end

  // Pipeline control: four stages, each advances when the next is free.
  logic [3:0] v_q;
  logic [3:0] en;
  always_comb begin
    en[3] = !v_q[3] || out_ready_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  // Float lane operands: left from low word; right from high word or bits 63:32.
  logic        ldbl, rdbl;
  logic [63:0] lbits, rbits;
  always_comb begin
    ldbl  = (fmt == FmtF64Mono) || (fmt == FmtF64Stereo);
    rdbl  = (fmt == FmtF64Stereo);
    lbits = in_data_i.frame_low;
    rbits = rdbl ? in_data_i.frame_high : {32'd0, in_data_i.frame_low[63:32]};
  end

  logic [15:0] lf, rf;
  pf16_fconv u_left (
    .clk_i, .en1_i(en[0]), .en2_i(en[1]), .en3_i(en[2]),
    .bits_i(lbits), .dbl_i(ldbl), .res_o(lf)
  );
  pf16_fconv u_right (
    .clk_i, .en1_i(en[0]), .en2_i(en[1]), .en3_i(en[2]),
    .bits_i(rbits), .dbl_i(rdbl), .res_o(rf)
  );

  // Integer results and the float selection travel alongside.
  typedef struct packed {
    logic [15:0] l;
    logic [15:0] r;
    logic        err;
    logic        lflt;
    logic        rflt;
  } side_t;

  side_t s_d;
  side_t s_q [3];
  logic [63:0] lo;
  always_comb begin
    lo = in_data_i.frame_low;
    s_d = '0;
    unique case (fmt)
      FmtU8Mono:    s_d.l = {lo[7] ^ 1'b1, lo[6:0], 8'd0};
      FmtU8Stereo: begin
        s_d.l = {lo[7] ^ 1'b1, lo[6:0], 8'd0};
        s_d.r = {lo[15] ^ 1'b1, lo[14:8], 8'd0};
      end
      FmtI16Mono:   s_d.l = lo[15:0];
      FmtI24Mono:   s_d.l = lo[23:8];
      FmtI32Mono:   s_d.l = lo[31:16];
      FmtI16Stereo: begin
        s_d.l = lo[15:0];
        s_d.r = lo[31:16];
      end
      FmtI24Stereo: begin
        s_d.l = lo[23:8];
        s_d.r = lo[47:32];
      end
      FmtI32Stereo: begin
        s_d.l = lo[31:16];
        s_d.r = lo[63:48];
      end
      FmtF32Mono, FmtF64Mono: s_d.lflt = 1'b1;
      FmtF32Stereo, FmtF64Stereo: begin
        s_d.lflt = 1'b1;
        s_d.rflt = 1'b1;
      end
      default: s_d.err = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s_q[0] <= s_d;
    if (en[1]) s_q[1] <= s_q[0];
    if (en[2]) s_q[2] <= s_q[1];
  end

  // Output register.
  pf16_out_t o_d, o_q;
  always_comb begin
    o_d.left_sample  = s_q[2].lflt ? lf : s_q[2].l;
    o_d.right_sample = s_q[2].rflt ? rf : s_q[2].r;
    o_d.format_error = s_q[2].err;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) o_q <= o_d;
  end

  assign out_valid_o = v_q[3];
  assign out_data_o  = o_q;

endmodule
